[design/pcfm_pkg.sv]
package pcfm_pkg;

  // Field widths
  localparam int unsigned CurW    = 24;
  localparam int unsigned FaultW  = 8;
  localparam int unsigned WdW     = 10;
  localparam int unsigned CfgIdxW = 2;

  // Stream widths
  localparam int unsigned InDataW  = 32;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 32;

  // Output beat bit positions
  localparam int unsigned OutOverChgBit  = 24;
  localparam int unsigned OutOverDisBit  = 25;
  localparam int unsigned OutSensorWdBit = 26;
  localparam int unsigned OutGoodBit     = 27;
  localparam int unsigned OutChargingBit = 28;
  localparam int unsigned OutChangedBit  = 29;

  // Register reset values
  localparam logic signed [CurW-1:0] ChargeLimitRst    = -24'sd20000;
  localparam logic signed [CurW-1:0] DischargeLimitRst = 24'sd20000;
  localparam logic signed [CurW-1:0] ChargingThreshRst = 24'sd0;
  localparam logic [WdW-1:0]         WdPeriodsRst      = 10'd20;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHARGE_LIMIT    = 2'd0,
    CFG_DISCHARGE_LIMIT = 2'd1,
    CFG_CHARGING_THRESH = 2'd2,
    CFG_WD_PERIODS      = 2'd3
  } cfg_idx_e;

  // Sensor fault codes
  typedef enum logic [FaultW-1:0] {
    SENS_OK           = 8'd0,
    SENS_OUT_OF_BOUND = 8'd1,
    SENS_DISCHARGE    = 8'd2,
    SENS_CHARGE       = 8'd3,
    SENS_WATCHDOG     = 8'd4
  } sens_fault_e;

  // One result beat
  typedef struct packed {
    logic                   changed;
    logic                   charging;
    logic                   good;
    logic                   sensor_wd;
    logic                   over_dis;
    logic                   over_chg;
    logic signed [CurW-1:0] current;
  } result_t;

endpackage

[design/pack_current_fault_monitor.sv]
// Channel   | Handshake                  | Payload
// s_axis    | s_axis_tvalid/tready       | tdata: fault byte, raw current; tuser: frame valid
// m_axis    | m_axis_tvalid/tready       | tdata: current, fault flags, good, charging, changed
// cfg       | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One beat per clock sustained while the result is not stalled. Each beat sits in
// the input register, is evaluated against the held state, and lands in the
// result register. The state is updated as a beat moves into the result
// register. Reset clears the held state and the valids and loads the register defaults.
// A stalled result stops the input register; the input side stays ready while
// that register is free or draining. Config writes are always taken.
module pack_current_fault_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] frame_fault_byte, [31:8] frame_current_raw
  input  logic [pcfm_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] frame_valid
  input  logic [pcfm_pkg::InUserW-1:0]    s_axis_tuser,
  // master stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [23:0] current_ma, [24] fault_over_charge, [25] fault_over_discharge,
  // [26] fault_sensor_watchdog, [27] monitor_good, [28] is_charging_now,
  // [29] charge_state_changed, [31:30] zero
  output logic [pcfm_pkg::OutDataW-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcfm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pcfm_pkg::CurW-1:0]       cfg_data_i
);

  // Config registers
  logic signed [pcfm_pkg::CurW-1:0] charge_limit_q, discharge_limit_q, charging_thresh_q;
  logic [pcfm_pkg::WdW-1:0]         wd_periods_q;

  // Input register
  logic                        in_valid_q;
  logic                        in_frame_q;
  logic [pcfm_pkg::FaultW-1:0] in_fault_q;
  logic [pcfm_pkg::CurW-1:0]   in_current_q;

  // Held state
  logic signed [pcfm_pkg::CurW-1:0] held_current_q, held_current_d;
  logic [pcfm_pkg::FaultW-1:0]      held_fault_q, held_fault_d;
  logic                             charging_q, charging_d;
  logic                             good_q, good_d;
  logic                             armed_q, armed_d;
  logic                             seen_q, seen_d;
  logic [pcfm_pkg::WdW-1:0]         wd_count_q, wd_count_d;

  // Result register
  logic              out_valid_q;
  pcfm_pkg::result_t res_q, res_d;

  logic                     s1_fire;
  logic [pcfm_pkg::WdW-1:0] wd_period;
  logic [pcfm_pkg::WdW-1:0] wd_inc;
  logic                     f_chg, f_dis, f_wd;

  assign s1_fire       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || s1_fire;
  assign cfg_ready_o   = 1'b1;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charge_limit_q    <= pcfm_pkg::ChargeLimitRst;
      discharge_limit_q <= pcfm_pkg::DischargeLimitRst;
      charging_thresh_q <= pcfm_pkg::ChargingThreshRst;
      wd_periods_q      <= pcfm_pkg::WdPeriodsRst;
    end else if (cfg_valid_i) begin
      case (pcfm_pkg::cfg_idx_e'(cfg_index_i))
        pcfm_pkg::CFG_CHARGE_LIMIT:    charge_limit_q    <= $signed(cfg_data_i);
        pcfm_pkg::CFG_DISCHARGE_LIMIT: discharge_limit_q <= $signed(cfg_data_i);
        pcfm_pkg::CFG_CHARGING_THRESH: charging_thresh_q <= $signed(cfg_data_i);
        pcfm_pkg::CFG_WD_PERIODS:      wd_periods_q      <= cfg_data_i[pcfm_pkg::WdW-1:0];
        default: ;
      endcase
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_frame_q   <= s_axis_tuser[0];
      in_fault_q   <= s_axis_tdata[pcfm_pkg::FaultW-1:0];
      in_current_q <= s_axis_tdata[pcfm_pkg::FaultW +: pcfm_pkg::CurW];
    end
  end

  // Watchdog, then frame capture, then fault checks and charging flag
  always_comb begin
    wd_period = (wd_periods_q == '0) ? pcfm_pkg::WdW'(1) : wd_periods_q;
    wd_inc    = wd_count_q + pcfm_pkg::WdW'(1);

    wd_count_d     = wd_count_q;
    seen_d         = seen_q;
    armed_d        = armed_q;
    held_current_d = held_current_q;
    held_fault_d   = held_fault_q;
    good_d         = good_q;
    charging_d     = charging_q;
    f_chg          = 1'b0;
    f_dis          = 1'b0;
    f_wd           = 1'b0;

    // freshness check runs before this period's frame
    if (armed_q) begin
      wd_count_d = wd_inc;
      if (wd_inc >= wd_period) begin
        wd_count_d = '0;
        if (!seen_q) begin
          f_wd = 1'b1;
        end else begin
          seen_d = 1'b0;
        end
      end
    end

    if (in_frame_q) begin
      seen_d         = 1'b1;
      held_current_d = $signed(in_current_q);
      held_fault_d   = in_fault_q;
      if (!armed_q) begin
        armed_d    = 1'b1;
        wd_count_d = '0;
      end
    end

    // priority: charge limit, discharge limit, sensor code
    if (held_current_d < charge_limit_q) begin
      f_chg = 1'b1;
    end else if (held_current_d > discharge_limit_q) begin
      f_dis = 1'b1;
    end else if (held_fault_d != pcfm_pkg::SENS_OK) begin
      case (pcfm_pkg::sens_fault_e'(held_fault_d))
        pcfm_pkg::SENS_OUT_OF_BOUND: f_wd  = 1'b1;
        pcfm_pkg::SENS_DISCHARGE:    f_dis = 1'b1;
        pcfm_pkg::SENS_CHARGE:       f_chg = 1'b1;
        pcfm_pkg::SENS_WATCHDOG:     f_wd  = 1'b1;
        default: ;
      endcase
    end else if (in_frame_q) begin
      good_d = 1'b1;
    end

    charging_d = !(held_current_d > charging_thresh_q);

    res_d.current   = held_current_d;
    res_d.over_chg  = f_chg;
    res_d.over_dis  = f_dis;
    res_d.sensor_wd = f_wd;
    res_d.good      = good_d;
    res_d.charging  = charging_d;
    res_d.changed   = charging_d != charging_q;
  end

  // Held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_current_q <= '0;
      held_fault_q   <= '0;
      charging_q     <= 1'b0;
      good_q         <= 1'b0;
      armed_q        <= 1'b0;
      seen_q         <= 1'b0;
      wd_count_q     <= '0;
    end else if (s1_fire) begin
      held_current_q <= held_current_d;
      held_fault_q   <= held_fault_d;
      charging_q     <= charging_d;
      good_q         <= good_d;
      armed_q        <= armed_d;
      seen_q         <= seen_d;
      wd_count_q     <= wd_count_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(pcfm_pkg::OutDataW - $bits(pcfm_pkg::result_t)){1'b0}}, res_q};

endmodule

[design/pcfm_checker.sv]
module pcfm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pcfm_pkg::OutDataW-1:0] m_axis_tdata
);

  logic good_seen_q;

  // remember that a good beat went out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_seen_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[pcfm_pkg::OutGoodBit]) begin
      good_seen_q <= 1'b1;
    end
  end

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // charge and discharge overcurrent are exclusive
  a_fault_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[pcfm_pkg::OutOverChgBit] &&
                        m_axis_tdata[pcfm_pkg::OutOverDisBit]))
    else $error("both overcurrent flags set");

  // monitor good is sticky
  a_good_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && good_seen_q |-> m_axis_tdata[pcfm_pkg::OutGoodBit])
    else $error("monitor good dropped");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[pcfm_pkg::OutDataW-1:pcfm_pkg::OutChangedBit+1] == '0)
    else $error("pad bits set");

endmodule

bind pack_current_fault_monitor pcfm_checker u_pcfm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
